>>> rtl/ata_pkg.sv
// Shared types and constants of the ATA PIO LBA28 host sequencer.
`default_nettype none
package ata_pkg;

  localparam int unsigned WORDS_PER_SECTOR = 256;
  localparam int unsigned MAX_SECTORS      = 255;

  // input item codes
  localparam logic [1:0] FN_REQ    = 2'd0;
  localparam logic [1:0] FN_STATUS = 2'd1;
  localparam logic [1:0] FN_DATA   = 2'd2;

  // result kinds
  localparam logic [2:0] K_RD   = 3'd0;
  localparam logic [2:0] K_WR   = 3'd1;
  localparam logic [2:0] K_HOST = 3'd2;
  localparam logic [2:0] K_DONE = 3'd3;
  localparam logic [2:0] K_ERR  = 3'd4;
  localparam logic [2:0] K_WANT = 3'd5;

  // error codes
  localparam logic [1:0] ERR_BAD     = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_DEVICE  = 2'd2;

  // command block offsets (block at 0x1F0), control port (0x3F6)
  localparam logic [3:0] P_DATA    = 4'd0;
  localparam logic [3:0] P_COUNT   = 4'd2;
  localparam logic [3:0] P_LBA_LO  = 4'd3;
  localparam logic [3:0] P_LBA_MID = 4'd4;
  localparam logic [3:0] P_LBA_HI  = 4'd5;
  localparam logic [3:0] P_DRIVE   = 4'd6;
  localparam logic [3:0] P_STATUS  = 4'd7;
  localparam logic [3:0] P_CTRL    = 4'd8;

  // status bits
  localparam int unsigned ST_BSY = 7;
  localparam int unsigned ST_DRQ = 3;
  localparam int unsigned ST_ERR = 0;

  localparam logic [7:0]  DRV_LBA      = 8'hE0;
  localparam logic [7:0]  CMD_READ     = 8'h20;
  localparam logic [7:0]  CMD_WRITE    = 8'h30;
  localparam logic [7:0]  CMD_FLUSH    = 8'hE7;
  localparam logic [27:0] LBA28_MAX    = 28'h0FFFFFFF;
  localparam logic [19:0] POLL_LIM_RST = 20'd1000000;

  // configuration register indexes
  localparam logic [1:0] CFG_PART_BASE  = 2'd0;
  localparam logic [1:0] CFG_PART_SIZE  = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;

  // result sequences the back end knows how to play
  typedef enum logic [3:0] {
    JB_ERR,        // error
    JB_POLL,       // status read
    JB_CMD,        // drive/count/lba/command writes, status read
    JB_WANT,       // ask host for a sector
    JB_RDW,        // data port read
    JB_HOST,       // word to host, data port read
    JB_HOST_POLL,  // word to host, status read
    JB_HOST_DONE,  // word to host, done
    JB_WRW,        // data port write
    JB_WR_POLL,    // data port write, four ctrl reads, status read
    JB_WR_DONE,    // data port write, four ctrl reads, done
    JB_FLUSH,      // flush command, status read
    JB_DONE        // done
  } job_code_t;

  typedef struct packed {
    job_code_t   code;
    logic [15:0] word;
    logic [27:0] sector;
    logic        dir;
    logic [1:0]  err;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/ata_front.sv
// Front end: configuration registers, request checks and transfer phase tracking.
`default_nettype none
module ata_front
  import ata_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_data,
  input  wire logic        in_fire,
  input  wire logic [1:0]  in_func,
  input  wire logic        in_is_write,
  input  wire logic [31:0] in_lba,
  input  wire logic [8:0]  in_count,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [15:0] in_data_word,
  output logic             push,
  output job_t             job
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT_BSY, PH_WAIT_DRQ, PH_READ_DATA, PH_WRITE_DATA,
    PH_FLUSH_WAIT1, PH_FLUSH_WAIT2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [27:0] cur_sector_r, cur_sector_nxt;
  logic [7:0]  sectors_left_r, sectors_left_nxt;
  logic [8:0]  word_index_r, word_index_nxt;
  logic [19:0] poll_count_r, poll_count_nxt;
  logic        write_dir_r, write_dir_nxt;
  logic [27:0] part_base_r;
  logic [28:0] part_size_r;
  logic [19:0] poll_limit_r;

  logic [32:0] range_end, abs_lba;
  logic        bad_req, timeout, bsy;
  logic        repoll, fin;
  logic [8:0]  wi_inc;
  logic [7:0]  left_dec;

  assign range_end = {1'b0, in_lba} + {24'd0, in_count};
  assign abs_lba   = {5'd0, part_base_r} + {1'b0, in_lba};
  assign bad_req   = (in_count == 9'd0) || (in_count > 9'(MAX_SECTORS)) ||
                     (part_size_r == 29'd0) || (range_end > {4'd0, part_size_r}) ||
                     (abs_lba > {5'd0, LBA28_MAX});
  assign timeout   = poll_count_r >= poll_limit_r;
  assign bsy       = in_status_byte[ST_BSY];
  assign wi_inc    = word_index_r + 9'd1;
  assign left_dec  = sectors_left_r - 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    cur_sector_nxt   = cur_sector_r;
    sectors_left_nxt = sectors_left_r;
    word_index_nxt   = word_index_r;
    poll_count_nxt   = poll_count_r;
    write_dir_nxt    = write_dir_r;
    push             = 1'b0;
    repoll           = 1'b0;
    fin              = 1'b0;
    job.code         = JB_POLL;
    job.word         = in_data_word;
    job.sector       = cur_sector_r;
    job.dir          = write_dir_r;
    job.err          = ERR_BAD;
    if (in_fire) begin
      case (in_func)
        FN_REQ: begin
          if (phase_r == PH_IDLE) begin
            push = 1'b1;
            if (bad_req) begin
              job.code = JB_ERR;
            end else begin
              cur_sector_nxt   = abs_lba[27:0];
              sectors_left_nxt = in_count[7:0];
              word_index_nxt   = 9'd0;
              write_dir_nxt    = in_is_write;
              phase_nxt        = PH_WAIT_BSY;
              poll_count_nxt   = 20'd1;
              job.code         = JB_POLL;
            end
          end
        end
        FN_STATUS: begin
          unique case (phase_r)
            PH_WAIT_BSY: begin
              if (!bsy) begin
                push           = 1'b1;
                job.code       = JB_CMD;
                phase_nxt      = PH_WAIT_DRQ;
                poll_count_nxt = 20'd1;
              end else begin
                repoll = 1'b1;
              end
            end
            PH_WAIT_DRQ: begin
              if (in_status_byte[ST_ERR]) begin
                push      = 1'b1;
                job.code  = JB_ERR;
                job.err   = ERR_DEVICE;
                phase_nxt = PH_IDLE;
              end else if (!bsy && in_status_byte[ST_DRQ]) begin
                push           = 1'b1;
                word_index_nxt = 9'd0;
                if (write_dir_r) begin
                  phase_nxt = PH_WRITE_DATA;
                  job.code  = JB_WANT;
                end else begin
                  phase_nxt = PH_READ_DATA;
                  job.code  = JB_RDW;
                end
              end else begin
                repoll = 1'b1;
              end
            end
            PH_FLUSH_WAIT1: begin
              if (!bsy) begin
                push           = 1'b1;
                job.code       = JB_FLUSH;
                phase_nxt      = PH_FLUSH_WAIT2;
                poll_count_nxt = 20'd1;
              end else begin
                repoll = 1'b1;
              end
            end
            PH_FLUSH_WAIT2: begin
              if (!bsy) begin
                push      = 1'b1;
                job.code  = JB_DONE;
                phase_nxt = PH_IDLE;
              end else begin
                repoll = 1'b1;
              end
            end
            default: ;
          endcase
        end
        FN_DATA: begin
          if (phase_r == PH_READ_DATA || phase_r == PH_WRITE_DATA) begin
            push           = 1'b1;
            word_index_nxt = wi_inc;
            if (wi_inc >= 9'(WORDS_PER_SECTOR)) begin
              fin = 1'b1;
            end else if (phase_r == PH_READ_DATA) begin
              job.code = JB_HOST;
            end else begin
              job.code = JB_WRW;
            end
          end
        end
        default: ;
      endcase

      // another status poll, or give up
      if (repoll) begin
        push = 1'b1;
        if (timeout) begin
          phase_nxt = PH_IDLE;
          job.code  = JB_ERR;
          job.err   = ERR_TIMEOUT;
        end else begin
          poll_count_nxt = poll_count_r + 20'd1;
          job.code       = JB_POLL;
        end
      end

      // last word of a sector
      if (fin) begin
        cur_sector_nxt   = cur_sector_r + 28'd1;
        sectors_left_nxt = left_dec;
        word_index_nxt   = 9'd0;
        if (left_dec != 8'd0 || write_dir_r) begin
          phase_nxt      = (left_dec != 8'd0) ? PH_WAIT_BSY : PH_FLUSH_WAIT1;
          poll_count_nxt = 20'd1;
          job.code       = (phase_r == PH_READ_DATA) ? JB_HOST_POLL : JB_WR_POLL;
        end else begin
          phase_nxt = PH_IDLE;
          job.code  = (phase_r == PH_READ_DATA) ? JB_HOST_DONE : JB_WR_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      cur_sector_r   <= '0;
      sectors_left_r <= '0;
      word_index_r   <= '0;
      poll_count_r   <= '0;
      write_dir_r    <= 1'b0;
      part_base_r    <= '0;
      part_size_r    <= '0;
      poll_limit_r   <= POLL_LIM_RST;
    end else begin
      phase_r        <= phase_nxt;
      cur_sector_r   <= cur_sector_nxt;
      sectors_left_r <= sectors_left_nxt;
      word_index_r   <= word_index_nxt;
      poll_count_r   <= poll_count_nxt;
      write_dir_r    <= write_dir_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PART_BASE:  part_base_r  <= cfg_data[27:0];
          CFG_PART_SIZE:  part_size_r  <= cfg_data;
          CFG_POLL_LIMIT: poll_limit_r <= cfg_data[19:0];
          default: ;
        endcase
      end
    end
  end

  // data phases only run with sectors outstanding
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ_DATA || phase_r == PH_WRITE_DATA) |-> sectors_left_r != 8'd0)
    else $error("data phase with no sectors left");
  // word index stays within one sector
  a_word_idx: assert property (@(posedge clk) disable iff (!rst_n)
    word_index_r < 9'(WORDS_PER_SECTOR))
    else $error("word index past sector end");
  // a wait always starts on its first poll
  a_poll_start: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (job.code == JB_CMD || job.code == JB_FLUSH)) |=> poll_count_r == 20'd1)
    else $error("poll count not restarted");

endmodule
`default_nettype wire

>>> rtl/ata_queue.sv
// Two-entry job queue between front and back end.
`default_nettype none
module ata_queue
  import ata_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      full,
  output logic      empty
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");

endmodule
`default_nettype wire

>>> rtl/ata_back.sv
// Back end: plays each job out as result beats through the output register.
`default_nettype none
module ata_back
  import ata_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  job_t       q_job,
  input  wire logic  q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0] out_kind,
  output logic [3:0] out_port,
  output logic [15:0] out_value,
  output logic [1:0] out_err_code,
  output logic       out_last
);

  job_t        cur_r;
  logic        cur_valid_r;
  logic [2:0]  idx_r;
  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [3:0]  port_r;
  logic [15:0] value_r;
  logic [1:0]  err_r;
  logic        last_r;

  logic [2:0]  b_kind;
  logic [3:0]  b_port;
  logic [15:0] b_value;
  logic [1:0]  b_err;
  logic        b_last;
  logic        load;

  // beat idx of the current job
  always_comb begin
    b_kind  = K_RD;
    b_port  = P_DATA;
    b_value = 16'd0;
    b_err   = ERR_BAD;
    b_last  = 1'b1;
    unique case (cur_r.code)
      JB_ERR: begin
        b_kind = K_ERR;
        b_err  = cur_r.err;
      end
      JB_POLL: b_port = P_STATUS;
      JB_CMD: begin
        b_kind = K_WR;
        b_last = 1'b0;
        case (idx_r)
          3'd0: begin
            b_port  = P_DRIVE;
            b_value = {8'd0, DRV_LBA | {4'd0, cur_r.sector[27:24]}};
          end
          3'd1: begin
            b_port  = P_COUNT;
            b_value = 16'd1;
          end
          3'd2: begin
            b_port  = P_LBA_LO;
            b_value = {8'd0, cur_r.sector[7:0]};
          end
          3'd3: begin
            b_port  = P_LBA_MID;
            b_value = {8'd0, cur_r.sector[15:8]};
          end
          3'd4: begin
            b_port  = P_LBA_HI;
            b_value = {8'd0, cur_r.sector[23:16]};
          end
          3'd5: begin
            b_port  = P_STATUS;
            b_value = {8'd0, cur_r.dir ? CMD_WRITE : CMD_READ};
          end
          default: begin
            b_kind = K_RD;
            b_port = P_STATUS;
            b_last = 1'b1;
          end
        endcase
      end
      JB_WANT: b_kind = K_WANT;
      JB_RDW:  b_port = P_DATA;
      JB_HOST, JB_HOST_POLL, JB_HOST_DONE: begin
        if (idx_r == 3'd0) begin
          b_kind  = K_HOST;
          b_value = cur_r.word;
          b_last  = 1'b0;
        end else if (cur_r.code == JB_HOST) begin
          b_port = P_DATA;
        end else if (cur_r.code == JB_HOST_POLL) begin
          b_port = P_STATUS;
        end else begin
          b_kind = K_DONE;
        end
      end
      JB_WRW: begin
        b_kind  = K_WR;
        b_value = cur_r.word;
      end
      JB_WR_POLL, JB_WR_DONE: begin
        b_last = 1'b0;
        if (idx_r == 3'd0) begin
          b_kind  = K_WR;
          b_value = cur_r.word;
        end else if (idx_r < 3'd5) begin
          b_port = P_CTRL;          // settle delay reads
        end else begin
          b_last = 1'b1;
          if (cur_r.code == JB_WR_POLL) b_port = P_STATUS;
          else                          b_kind = K_DONE;
        end
      end
      JB_FLUSH: begin
        if (idx_r == 3'd0) begin
          b_kind  = K_WR;
          b_port  = P_STATUS;
          b_value = {8'd0, CMD_FLUSH};
          b_last  = 1'b0;
        end else begin
          b_port = P_STATUS;
        end
      end
      JB_DONE: b_kind = K_DONE;
      default: ;
    endcase
  end

  assign load  = cur_valid_r && (!out_valid_r || out_ready);
  assign q_pop = !q_empty && (!cur_valid_r || (load && b_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= 3'd0;
      end else if (load) begin
        cur_valid_r <= !b_last;
        idx_r       <= b_last ? 3'd0 : idx_r + 3'd1;
      end
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_job;
    if (load) begin
      kind_r  <= b_kind;
      port_r  <= b_port;
      value_r <= b_value;
      err_r   <= b_err;
      last_r  <= b_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_port     = port_r;
  assign out_value    = value_r;
  assign out_err_code = err_r;
  assign out_last     = last_r;

  // a stalled beat keeps the sequencer where it is
  a_hold_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(idx_r))
    else $error("beat index moved during stall");
  // no job runs longer than seven beats
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> idx_r <= 3'd6)
    else $error("beat index past job end");
  // a stalled beat stays valid with its payload unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable({kind_r, port_r, value_r, err_r, last_r})))
    else $error("result beat changed during stall");

endmodule
`default_nettype wire

>>> rtl/ata_pio_lba28_host_sequencer.sv
// Top level of the ATA PIO LBA28 host sequencer.
`default_nettype none
// Host side of ATA PIO LBA28 sector transfers. Requests, status bytes read
// back from the device and data words enter on the in_ channel; the block
// answers with a stream of result beats on the out_ channel (port reads and
// writes to issue on the bus, words for the host, done, error, or a request
// for the next host sector). out_last marks the final beat caused by one
// input item. The front end checks requests and tracks the transfer phase,
// and takes one input beat per cycle while its two-entry job queue has room;
// items that do not fit the current phase are taken and dropped. The back
// end turns each job into 1 to 7 result beats, one per cycle through the
// output register while out_ready is high, so an item yields 1 beat for a
// poll or a written data word, 2 for a read data word, the last word of a
// read sector or a flush issue, 6 for the last word of a written sector
// and 7 for a command issue.
// Configuration (part_base, part_size, poll_limit at cfg_index 0..2) is
// always ready and must only be written while the block is idle; there is
// no start-up sweep after reset.
module ata_pio_lba28_host_sequencer
  import ata_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic        in_is_write,
  input  wire logic [31:0] in_lba,
  input  wire logic [8:0]  in_count,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [15:0] in_data_word,
  // result beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [3:0]       out_port,
  output logic [15:0]      out_value,
  output logic [1:0]       out_err_code,
  output logic             out_last
);

  logic in_fire;
  logic push, pop, q_full, q_empty;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;

  // phase tracking and request checks
  ata_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_fire        (in_fire),
    .in_func        (in_func),
    .in_is_write    (in_is_write),
    .in_lba         (in_lba),
    .in_count       (in_count),
    .in_status_byte (in_status_byte),
    .in_data_word   (in_data_word),
    .push           (push),
    .job            (push_job)
  );

  // decouples item acceptance from beat output
  ata_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // beat sequencer and output register
  ata_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_job        (pop_job),
    .q_empty      (q_empty),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_port     (out_port),
    .out_value    (out_value),
    .out_err_code (out_err_code),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the ATA PIO LBA28 host sequencer.
`default_nettype none
module tb_top;
  import ata_pkg::*;

  // Unused input code: the block must drop it.
  localparam logic [1:0] FN_NONE = 2'd3;
  // Port field of results that address no register.
  localparam logic [3:0] NO_PORT = 4'd0;
  // Cycles the block may still spend on a beat that yields nothing.
  localparam int SETTLE_CYCLES = 16;

  // Transfer phase of the sequencer, our own view of it.
  typedef enum logic [3:0] {
    S_IDLE, S_WAIT_BSY, S_WAIT_DRQ, S_READ_DATA, S_WRITE_DATA, S_FLUSH1, S_FLUSH2
  } xfer_phase_t;

  typedef struct packed {
    xfer_phase_t phase;
    logic [27:0] sector;
    logic [7:0]  left;
    logic [8:0]  widx;
    logic [19:0] polls;
    logic        wdir;
  } xfer_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        is_write;
    logic [31:0] lba;
    logic [8:0]  count;
    logic [7:0]  status;
    logic [15:0] word;
  } bus_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  port;
    logic [15:0] value;
    logic [1:0]  err;
    logic        last;
  } bus_op_t;

  // New state plus the up to seven result beats one input beat causes.
  typedef struct packed {
    xfer_state_t      st;
    logic [2:0]       n;
    bus_op_t [6:0]    ops;
  } xfer_step_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index      = '0;
  logic [28:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func        = '0;
  logic        in_is_write    = 1'b0;
  logic [31:0] in_lba         = '0;
  logic [8:0]  in_count       = '0;
  logic [7:0]  in_status_byte = '0;
  logic [15:0] in_data_word   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  out_kind;
  logic [3:0]  out_port;
  logic [15:0] out_value;
  logic [1:0]  out_err_code;
  logic        out_last;

  ata_pio_lba28_host_sequencer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_is_write    (in_is_write),
    .in_lba         (in_lba),
    .in_count       (in_count),
    .in_status_byte (in_status_byte),
    .in_data_word   (in_data_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_port       (out_port),
    .out_value      (out_value),
    .out_err_code   (out_err_code),
    .out_last       (out_last)
  );

  // Register shadow; only changes while the block is idle.
  logic [27:0] part_base  = '0;
  logic [28:0] part_size  = '0;
  logic [19:0] poll_limit = POLL_LIM_RST;

  bus_item_t   pending_q[$];   // beats waiting for the driver
  bus_op_t     bus_ops_q[$];   // result beats still owed by the block
  xfer_state_t plan_st = '0;   // phase as seen by the stimulus generator
  xfer_state_t seq_st  = '0;   // phase as of the last accepted beat
  bit          no_gaps = 1'b0; // both sides run flat out while set
  bit          doomed  = 1'b0; // current request is meant to end in a device error
  int          mon_errs = 0;
  int          gen_errs = 0;
  int          ctrl_beats = 0; // requests and status beats, data words excluded

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------------
  // Sequencer prediction
  // ------------------------------------------------------------------

  function automatic xfer_step_t add_op(xfer_step_t o, logic [2:0] k, logic [3:0] p,
                                        logic [15:0] v, logic [1:0] e);
    o.ops[o.n] = '{kind: k, port: p, value: v, err: e, last: 1'b0};
    o.n = o.n + 3'd1;
    return o;
  endfunction

  // Arms a fresh status wait: first poll goes out right away.
  function automatic xfer_step_t first_poll(xfer_step_t o, xfer_phase_t ph);
    o.st.phase = ph;
    o.st.polls = 20'd1;
    return add_op(o, K_RD, P_STATUS, '0, '0);
  endfunction

  // Applies one input beat to a transfer state; returns the new state and
  // the result beats it causes, in bus order.
  function automatic xfer_step_t next_xfer(xfer_state_t s, bus_item_t it);
    xfer_step_t  o;
    logic [63:0] abs_lba;
    logic        polling;
    logic        rdy;
    logic        rd;
    o = '0;
    o.st = s;
    case (it.func)
      FN_REQ: if (s.phase == S_IDLE) begin
        abs_lba = 64'(part_base) + 64'(it.lba);
        if (it.count == '0 || it.count > MAX_SECTORS || part_size == '0 ||
            64'(it.lba) + 64'(it.count) > 64'(part_size) || abs_lba > 64'(LBA28_MAX)) begin
          o = add_op(o, K_ERR, NO_PORT, '0, ERR_BAD);
        end else begin
          o.st.sector = abs_lba[27:0];
          o.st.left   = it.count[7:0];
          o.st.widx   = '0;
          o.st.wdir   = it.is_write;
          o = first_poll(o, S_WAIT_BSY);
        end
      end
      FN_STATUS: begin
        polling = 1'b1;
        rdy     = 1'b0;
        case (s.phase)
          S_WAIT_BSY, S_FLUSH1, S_FLUSH2: rdy = !it.status[ST_BSY];
          S_WAIT_DRQ: rdy = !it.status[ST_BSY] && it.status[ST_DRQ];
          default: polling = 1'b0;
        endcase
        // ERR wins over both ready and timeout while waiting for DRQ
        if (s.phase == S_WAIT_DRQ && it.status[ST_ERR]) begin
          o.st.phase = S_IDLE;
          o = add_op(o, K_ERR, NO_PORT, '0, ERR_DEVICE);
        end else if (polling && !rdy) begin
          if (s.polls >= poll_limit) begin
            o.st.phase = S_IDLE;
            o = add_op(o, K_ERR, NO_PORT, '0, ERR_TIMEOUT);
          end else begin
            o.st.polls = s.polls + 20'd1;
            o = add_op(o, K_RD, P_STATUS, '0, '0);
          end
        end else if (polling) begin
          case (s.phase)
            S_WAIT_BSY: begin
              o = add_op(o, K_WR, P_DRIVE, 16'(DRV_LBA | 8'(s.sector[27:24])), '0);
              o = add_op(o, K_WR, P_COUNT, 16'd1, '0);
              o = add_op(o, K_WR, P_LBA_LO, 16'(s.sector[7:0]), '0);
              o = add_op(o, K_WR, P_LBA_MID, 16'(s.sector[15:8]), '0);
              o = add_op(o, K_WR, P_LBA_HI, 16'(s.sector[23:16]), '0);
              o = add_op(o, K_WR, P_STATUS, 16'(s.wdir ? CMD_WRITE : CMD_READ), '0);
              o = first_poll(o, S_WAIT_DRQ);
            end
            S_WAIT_DRQ: begin
              o.st.widx = '0;
              if (s.wdir) begin
                o.st.phase = S_WRITE_DATA;
                o = add_op(o, K_WANT, NO_PORT, '0, '0);
              end else begin
                o.st.phase = S_READ_DATA;
                o = add_op(o, K_RD, P_DATA, '0, '0);
              end
            end
            S_FLUSH1: begin
              o = add_op(o, K_WR, P_STATUS, 16'(CMD_FLUSH), '0);
              o = first_poll(o, S_FLUSH2);
            end
            default: begin
              o.st.phase = S_IDLE;
              o = add_op(o, K_DONE, NO_PORT, '0, '0);
            end
          endcase
        end
      end
      FN_DATA: if (s.phase == S_READ_DATA || s.phase == S_WRITE_DATA) begin
        rd = (s.phase == S_READ_DATA);
        o = add_op(o, rd ? K_HOST : K_WR, rd ? NO_PORT : P_DATA, it.word, '0);
        o.st.widx = s.widx + 9'd1;
        if (o.st.widx >= WORDS_PER_SECTOR) begin
          // written sector: four alt-status reads as a settle delay
          if (!rd) repeat (4) o = add_op(o, K_RD, P_CTRL, '0, '0);
          o.st.sector = s.sector + 28'd1;   // wraps past 28 bits
          o.st.left   = s.left - 8'd1;
          o.st.widx   = '0;
          if (o.st.left != '0) o = first_poll(o, S_WAIT_BSY);
          else if (s.wdir) o = first_poll(o, S_FLUSH1);
          else begin
            o.st.phase = S_IDLE;
            o = add_op(o, K_DONE, NO_PORT, '0, '0);
          end
        end else if (rd) begin
          o = add_op(o, K_RD, P_DATA, '0, '0);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // ------------------------------------------------------------------
  // Driver: presents queued beats, predicts on acceptance
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    xfer_step_t st;
    bus_op_t    op;
    bit         took;
    int         i;
    took = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      seq_st = '0;
    end else begin
      if (in_valid && in_ready) begin
        st = next_xfer(seq_st, pending_q[0]);
        seq_st = st.st;
        for (i = 0; i < int'(st.n); i++) begin
          op = st.ops[i];
          op.last = (i == int'(st.n) - 1);
          bus_ops_q.push_back(op);
        end
        void'(pending_q.pop_front());
        took = 1'b1;
      end
      if (!in_valid || took) begin
        if (pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= 21)) begin
          in_valid       <= 1'b1;
          in_func        <= pending_q[0].func;
          in_is_write    <= pending_q[0].is_write;
          in_lba         <= pending_q[0].lba;
          in_count       <= pending_q[0].count;
          in_status_byte <= pending_q[0].status;
          in_data_word   <= pending_q[0].word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare of result beats
  // ------------------------------------------------------------------
  function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
    if (want === got) return 0;
    $error("%s: expected %0h, got %0h", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    bus_op_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_ops_q.size() == 0) begin
          $error("result beat with nothing owed: kind %0d port %0d", out_kind, out_port);
          mon_errs++;
        end else begin
          want = bus_ops_q.pop_front();
          mon_errs += field_diff("kind", 16'(want.kind), 16'(out_kind));
          mon_errs += field_diff("port", 16'(want.port), 16'(out_port));
          mon_errs += field_diff("value", want.value, out_value);
          mon_errs += field_diff("err_code", 16'(want.err), 16'(out_err_code));
          mon_errs += field_diff("last", 16'(want.last), 16'(out_last));
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= 21);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  // Beat with every field random; callers then set what matters.
  function automatic bus_item_t scramble(logic [1:0] f);
    bus_item_t it;
    it.func     = f;
    it.is_write = 1'($urandom);
    it.lba      = $urandom;
    it.count    = 9'($urandom);
    it.status   = 8'($urandom);
    it.word     = 16'($urandom);
    return it;
  endfunction

  task automatic send(bus_item_t it);
    xfer_step_t st;
    while (pending_q.size() >= 4) @(negedge clk);
    pending_q.push_back(it);
    st = next_xfer(plan_st, it);
    plan_st = st.st;
  endtask

  // Waits until every queued beat is taken and every owed result seen.
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_q.size() != 0 || bus_ops_q.size() != 0) && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    if (pending_q.size() != 0 || bus_ops_q.size() != 0) begin
      $error("block stuck: %0d beats unsent, %0d results owed",
             pending_q.size(), bus_ops_q.size());
      gen_errs++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [28:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PART_BASE:  part_base  = val[27:0];
      CFG_PART_SIZE:  part_size  = val[28:0];
      CFG_POLL_LIMIT: poll_limit = val[19:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [27:0] base, logic [28:0] size, logic [19:0] lim);
    settle();
    cfg_write(CFG_PART_BASE, 29'(base));
    cfg_write(CFG_PART_SIZE, size);
    cfg_write(CFG_POLL_LIMIT, 29'(lim));
    @(negedge clk);
  endtask

  task automatic req(logic wr, logic [31:0] lba, logic [8:0] cnt);
    bus_item_t it;
    it = scramble(FN_REQ);
    it.is_write = wr;
    it.lba      = lba;
    it.count    = cnt;
    send(it);
  endtask

  task automatic status(logic [7:0] sb);
    bus_item_t it;
    it = scramble(FN_STATUS);
    it.status = sb;
    send(it);
  endtask

  // Random request, mostly in range; long ones are cut short by a device error.
  task automatic random_request();
    bus_item_t it;
    longint    top;
    int        r;
    it = scramble(FN_REQ);
    r = $urandom_range(99);
    doomed = 1'b0;
    if (r < 60) it.count = 9'd1;
    else if (r < 80) it.count = 9'($urandom_range(3, 2));
    else begin
      it.count = 9'($urandom_range(255, 4));
      doomed = 1'b1;
    end
    // highest lba that keeps both the range and the 28-bit sum legal
    top = longint'(part_size) - longint'(it.count);
    if (longint'(LBA28_MAX - part_base) < top) top = longint'(LBA28_MAX - part_base);
    r = $urandom_range(99);
    if (top < 0 || r < 10) begin
      case ($urandom_range(3))
        0: it.count = '0;
        1: it.count = 9'($urandom_range(511, 256));
        2: if (top >= 0) it.lba = 32'(top + 1);
        default: it.lba = 32'hFFFFFFFF - 32'($urandom_range(15));
      endcase
    end else begin
      case (r % 3)
        0: it.lba = '0;
        1: it.lba = 32'(top);
        default: it.lba = $urandom_range(32'(top));
      endcase
    end
    send(it);
  endtask

  // Picks the next beat from the planned phase: mostly well-formed traffic,
  // with some beats that do not fit the phase and must be dropped.
  task automatic next_beat();
    bus_item_t it;
    int        r;
    if ($urandom_range(99) < 7) begin
      r = $urandom_range(2);
      case (plan_st.phase)
        S_IDLE: it = scramble(r == 0 ? FN_STATUS : r == 1 ? FN_DATA : FN_NONE);
        S_READ_DATA, S_WRITE_DATA:
          it = scramble(r == 0 ? FN_REQ : r == 1 ? FN_STATUS : FN_NONE);
        default: it = scramble(r == 0 ? FN_REQ : r == 1 ? FN_DATA : FN_NONE);
      endcase
      send(it);
    end else begin
      r = $urandom_range(99);
      case (plan_st.phase)
        S_IDLE: begin
          random_request();
          ctrl_beats++;
        end
        S_READ_DATA, S_WRITE_DATA: send(scramble(FN_DATA));
        S_WAIT_DRQ: begin
          it = scramble(FN_STATUS);
          if (doomed || r < 5) it.status[ST_ERR] = 1'b1;
          else if (r < 30) begin
            it.status[ST_ERR] = 1'b0;
            if ($urandom_range(1) == 1) it.status[ST_BSY] = 1'b1;
            else it.status[ST_DRQ] = 1'b0;
          end else begin
            it.status[ST_BSY] = 1'b0;
            it.status[ST_DRQ] = 1'b1;
            it.status[ST_ERR] = 1'b0;
          end
          send(it);
          ctrl_beats++;
        end
        default: begin
          it = scramble(FN_STATUS);
          it.status[ST_BSY] = (r < 30);
          send(it);
          ctrl_beats++;
        end
      endcase
    end
  endtask

  // One register setting; runs until the quota is met and the block is idle.
  task automatic run_phase(logic [27:0] base, logic [28:0] size, logic [19:0] lim,
                           int quota);
    int start;
    configure(base, size, lim);
    start = ctrl_beats;
    while (ctrl_beats - start < quota || plan_st.phase != S_IDLE) begin
      next_beat();
      // now and then hold the sender until every result is back
      if (plan_st.phase != S_IDLE && $urandom_range(59) == 0) settle();
    end
  endtask

  initial begin
    logic [27:0] rb;
    logic [28:0] rs;
    logic [19:0] rl;
    wait (rst_n == 1'b1);
    @(negedge clk);

    // Reset registers: empty partition rejects every request.
    req(1'b0, 32'd0, 9'd1);
    req(1'b1, 32'hFFFFFFFF, 9'd255);
    status(8'hFF);                          // idle: dropped
    send(scramble(FN_DATA));                // idle: dropped
    send(scramble(FN_NONE));                // unused code: dropped

    // Partition at the top of the 28-bit space, two polls per wait.
    configure(28'h0FFFFFF0, 29'h10000000, 20'd2);
    req(1'b0, 32'd0, 9'd0);                 // zero count
    req(1'b0, 32'd0, 9'd256);               // one past the sector limit
    req(1'b1, 32'd0, 9'd511);
    req(1'b0, 32'h10, 9'd1);                // absolute lba needs 29 bits
    req(1'b0, 32'h0F, 9'd1);                // last addressable sector
    status(8'h80);
    status(8'hFF);                          // still busy at the limit: timeout
    req(1'b1, 32'd0, 9'd255);
    status(8'h00);                          // command issue, seven beats
    status(8'h81);                          // ERR even with BSY set
    req(1'b0, 32'h0F, 9'd1);
    status(8'h7F);
    status(8'h88);                          // DRQ under BSY is not ready
    status(8'h76);                          // no DRQ at the limit: timeout

    no_gaps = 1'b1;
    run_phase(28'd0, 29'h10000000, 20'hFFFFF, 45);
    no_gaps = 1'b0;
    run_phase(28'h0FFFFFFE, 29'h10000000, POLL_LIM_RST, 35);  // sector wrap
    run_phase(LBA28_MAX, 29'd5, 20'd1, 30);
    run_phase(28'd0, 29'd1, 20'd0, 25);                       // zero limit acts as one
    while (ctrl_beats < 270) begin
      rb = 28'($urandom);
      rs = ($urandom_range(3) == 0) ? 29'h10000000 : 29'($urandom_range(4000, 1));
      case ($urandom_range(4))
        0: rl = 20'd1;
        1: rl = 20'd2;
        2: rl = 20'd3;
        3: rl = 20'd7;
        default: rl = 20'd400;
      endcase
      run_phase(rb, rs, rl, 35);
    end

    settle();
    if (mon_errs + gen_errs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
